// File: design/assert_macros.svh
// Assertion macros used by the RTL of the add/sub/mul/div unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: design/sasmd_pkg.sv
// Types and codes of the signed add/sub/mul/div unit.
`default_nettype none
package sasmd_pkg;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALU,
		ST_ABS_A,
		ST_ABS_B,
		ST_ITER,
		ST_SIGN
	} state_t;

endpackage
`default_nettype wire

// File: design/signed_add_sub_mul_div_unit.sv
// Signed add / subtract / multiply / divide unit around one shared adder.
//
//  channel   direction  tdata                            tuser
//  s_axis    in         operand_a, operand_b (low first)  kind
//  m_axis    out        result_value                      divide_by_zero
//
// Add and subtract go through ST_ALU before the result is loaded; a divide by zero
// loads its result straight from ST_IDLE. Multiply and divide run two magnitude
// steps, DATA_WIDTH shift-add or shift-subtract steps and one sign step, all on
// the single DATA_WIDTH+1 bit adder. The input is not ready while an item is in
// work; a waiting result stalls only the next acceptance. arst_n clears control.
`default_nettype none
`include "assert_macros.svh"
module signed_add_sub_mul_div_unit
	import sasmd_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// operand_a [DATA_WIDTH-1:0], operand_b [2*DATA_WIDTH-1:DATA_WIDTH], zero fill
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// kind [1:0]
	input  wire logic [1:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// result_value [DATA_WIDTH-1:0], zero fill
	output logic [((DATA_WIDTH+7)/8)*8-1:0]             m_tdata,
	// divide_by_zero [0]
	output logic                                        m_tuser
);

	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	state_t                  state_q, state_d;
	kind_t                   op_q;
	logic                    neg_q;
	logic [DATA_WIDTH-1:0]   x_q;
	logic [DATA_WIDTH-1:0]   y_q;
	logic [DATA_WIDTH-1:0]   acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DATA_WIDTH-1:0]   res_q;
	logic                    dz_q;
	logic                    m_valid_q;

	logic [DATA_WIDTH-1:0]   add_x, add_y;
	logic                    add_sub;
	logic [DATA_WIDTH:0]     add_sum;
	logic [DATA_WIDTH-1:0]   rem_sh;
	logic [DATA_WIDTH-1:0]   fin_val;
	logic                    accept;
	logic                    load_out;
	logic [DATA_WIDTH-1:0]   in_a, in_b;
	kind_t                   in_kind;

	assign in_a    = s_tdata[DATA_WIDTH-1:0];
	assign in_b    = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign in_kind = kind_t'(s_tuser);
	assign accept  = s_tvalid && s_tready;
	assign rem_sh  = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
	assign fin_val = (op_q == KIND_MUL) ? acc_q : x_q;

	// Shared adder: carry out of the top bit means x >= y when subtracting.
	assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
		+ {{DATA_WIDTH{1'b0}}, add_sub};

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load_out = 1'b0;
		add_x    = x_q;
		add_y    = y_q;
		add_sub  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !m_valid_q || m_tready;
				if (s_tvalid && s_tready) begin
					if (in_kind == KIND_ADD || in_kind == KIND_SUB) begin
						state_d = ST_ALU;
					end else if (in_kind == KIND_DIV && in_b == '0) begin
						load_out = 1'b1;
					end else begin
						state_d = ST_ABS_A;
					end
				end
			end
			ST_ALU: begin
				add_sub  = (op_q == KIND_SUB);
				load_out = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_ABS_A: begin
				add_x   = '0;
				add_y   = x_q;
				add_sub = 1'b1;
				state_d = ST_ABS_B;
			end
			ST_ABS_B: begin
				add_x   = '0;
				add_y   = y_q;
				add_sub = 1'b1;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				if (op_q == KIND_MUL) begin
					add_x = acc_q;
					add_y = x_q;
				end else begin
					add_x   = rem_sh;
					add_y   = y_q;
					add_sub = 1'b1;
				end
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				add_x    = '0;
				add_y    = fin_val;
				add_sub  = 1'b1;
				load_out = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_kind;
			x_q   <= in_a;
			y_q   <= in_b;
			neg_q <= in_a[DATA_WIDTH-1] ^ in_b[DATA_WIDTH-1];
			acc_q <= '0;
		end
		unique case (state_q)
			ST_ABS_A: begin
				if (x_q[DATA_WIDTH-1]) begin
					x_q <= add_sum[DATA_WIDTH-1:0];
				end
			end
			ST_ABS_B: begin
				if (y_q[DATA_WIDTH-1]) begin
					y_q <= add_sum[DATA_WIDTH-1:0];
				end
				cnt_q <= CNT_W'(DATA_WIDTH);
			end
			ST_ITER: begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (op_q == KIND_MUL) begin
					if (y_q[0]) begin
						acc_q <= add_sum[DATA_WIDTH-1:0];
					end
					x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
					y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
				end else begin
					// restoring step: keep the difference when it did not borrow
					acc_q <= add_sum[DATA_WIDTH] ? add_sum[DATA_WIDTH-1:0] : rem_sh;
					x_q   <= {x_q[DATA_WIDTH-2:0], add_sum[DATA_WIDTH]};
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			priority if (state_q == ST_IDLE) begin
				res_q <= '0;
				dz_q  <= 1'b1;
			end else if (state_q == ST_SIGN) begin
				res_q <= neg_q ? add_sum[DATA_WIDTH-1:0] : fin_val;
				dz_q  <= 1'b0;
			end else begin
				res_q <= add_sum[DATA_WIDTH-1:0];
				dz_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = dz_q;

	always_comb begin
		m_tdata                 = '0;
		m_tdata[DATA_WIDTH-1:0] = res_q;
	end

	`ASSERT_PROP(a_no_overwrite, clk, arst_n, !load_out || !m_valid_q || m_tready,
		"result overwritten before transfer")
	`ASSERT_PROP(a_dz_zero, clk, arst_n, !(m_valid_q && dz_q) || res_q == '0,
		"divide by zero with nonzero result")
	`ASSERT_NEXT(a_abs_to_iter, clk, arst_n, state_q == ST_ABS_B,
		state_q == ST_ITER && cnt_q == CNT_W'(DATA_WIDTH),
		"iteration did not start with full count")

endmodule
`default_nettype wire
